[src/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg
// shared types and constants of the extended gcd block
// ----------------------------------------------------------------------------
package egcd_pkg;
   localparam int DATA_WIDTH = 64;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   typedef logic [DATA_WIDTH-1:0] word_type;

   // classified job handed from front to back
   typedef struct packed {
      word_type big;
      word_type sml;
      logic     swapped;
   } job_type;
endpackage

[src/egcd_front.sv]
// ----------------------------------------------------------------------------
// egcd_front
// accepts operand pairs, orders them and queues them for the back end
// ----------------------------------------------------------------------------
module egcd_front import egcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_start,
   input  word_type req_value_a,
   input  word_type req_value_b,
   output logic     req_busy,
   output logic     job_valid,
   output job_type  job_data,
   input  logic     job_take
);
   job_type queue_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_WIDTH:0]   count_ff;
   logic push;
   job_type job_in;

   assign req_busy  = (count_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
   assign push      = req_start && !req_busy;
   assign job_valid = (count_ff != '0);
   assign job_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      if (req_value_b > req_value_a) begin
         job_in = '{big: req_value_b, sml: req_value_a, swapped: 1'b1};
      end else begin
         job_in = '{big: req_value_a, sml: req_value_b, swapped: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (job_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(job_take);
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_in;
      end
   end
endmodule

[src/egcd_back.sv]
// ----------------------------------------------------------------------------
// egcd_back
// runs the euclid recurrence with a radix-2 divider and shift-add multiplies
// ----------------------------------------------------------------------------
module egcd_back import egcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job_data,
   output logic     job_take,
   output logic     rsp_strobe,
   output word_type rsp_gcd_value,
   output word_type rsp_coeff_a,
   output word_type rsp_coeff_b
);
   typedef enum logic [1:0] {IDLE, DIVIDE, UPDATE, DONE} state_type;
   state_type state_ff;
   word_type big_ff, small_ff, px_ff, py_ff, cx_ff, cy_ff;
   word_type quo_ff, rem_ff, tx_ff, ty_ff;
   logic swapped_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [DATA_WIDTH:0] rem_shift;
   word_type rem_trial;
   logic rem_ge;

   assign job_take  = (state_ff == IDLE) && job_valid;
   assign rem_shift = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign rem_ge    = rem_shift >= {1'b0, small_ff};
   assign rem_trial = rem_shift[DATA_WIDTH-1:0] - small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (state_ff == DONE);
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  big_ff     <= job_data.big;
                  small_ff   <= job_data.sml;
                  swapped_ff <= job_data.swapped;
                  px_ff <= word_type'(1); py_ff <= '0;
                  cx_ff <= '0; cy_ff <= word_type'(1);
                  quo_ff <= job_data.big;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= (job_data.sml == '0) ? DONE : DIVIDE;
               end
            end
            DIVIDE: begin
               rem_ff <= rem_ge ? rem_trial : rem_shift[DATA_WIDTH-1:0];
               quo_ff <= {quo_ff[DATA_WIDTH-2:0], rem_ge};
               if (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1)) begin
                  cnt_ff <= '0;
                  tx_ff <= '0;
                  ty_ff <= '0;
                  state_ff <= UPDATE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            UPDATE: begin
               if (rem_ff == '0) begin
                  state_ff <= DONE;
               end else if (cnt_ff == CNT_WIDTH'(DATA_WIDTH)) begin
                  px_ff <= cx_ff; py_ff <= cy_ff;
                  cx_ff <= px_ff - tx_ff; cy_ff <= py_ff - ty_ff;
                  big_ff <= small_ff; small_ff <= rem_ff;
                  quo_ff <= small_ff; rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= DIVIDE;
               end else begin
                  // shift-add product of quotient with both coefficients
                  tx_ff <= (tx_ff << 1) + (quo_ff[DATA_WIDTH-1] ? cx_ff : '0);
                  ty_ff <= (ty_ff << 1) + (quo_ff[DATA_WIDTH-1] ? cy_ff : '0);
                  quo_ff <= quo_ff << 1;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            DONE: begin
               if (small_ff == '0) begin
                  rsp_gcd_value <= big_ff;
                  rsp_coeff_a <= swapped_ff ? '0 : word_type'(1);
                  rsp_coeff_b <= swapped_ff ? word_type'(1) : '0;
               end else begin
                  rsp_gcd_value <= small_ff;
                  rsp_coeff_a <= swapped_ff ? cy_ff : cx_ff;
                  rsp_coeff_b <= swapped_ff ? cx_ff : cy_ff;
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

[src/extended_gcd_bezout.sv]
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// gcd and bezout coefficients of two unsigned operands
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue holds
// ordered operands while the back end works. Each euclid step runs a radix-2
// division, and every step but the last adds a shift-add multiply; when the
// smaller operand is zero the back end skips both and goes straight to its
// done state. Up to roughly 93 steps are needed for 64-bit inputs. Items wait
// in the queue meanwhile.
// The result appears for one cycle with rsp_strobe; the receiver cannot stall.
module extended_gcd_bezout import egcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  word_type req_value_a,
   input  word_type req_value_b,
   output logic     rsp_strobe,
   output word_type rsp_gcd_value,
   output word_type rsp_coeff_a,
   output word_type rsp_coeff_b
);
   logic    job_valid, job_take;
   job_type job_data;

   egcd_front u_front (
      .clock, .reset, .req_start(start), .req_value_a, .req_value_b,
      .req_busy(busy), .job_valid, .job_data, .job_take
   );

   egcd_back u_back (
      .clock, .reset, .job_valid, .job_data, .job_take,
      .rsp_strobe, .rsp_gcd_value, .rsp_coeff_a, .rsp_coeff_b
   );
endmodule

[src/egcd_checker.sv]
// ----------------------------------------------------------------------------
// egcd_checker
// port-level assertions on the extended gcd block
// ----------------------------------------------------------------------------
module egcd_checker import egcd_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     busy,
   input logic     rsp_strobe,
   input word_type rsp_gcd_value,
   input word_type rsp_coeff_a,
   input word_type rsp_coeff_b
);
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held two cycles");
   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe) else $error("strobe right after reset");
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !busy) else $error("busy right after reset");
   a_zero_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_gcd_value == '0) |-> (rsp_coeff_a == word_type'(1)
      && rsp_coeff_b == '0)) else $error("bad zero gcd result");
endmodule

bind extended_gcd_bezout egcd_checker u_checker (
   .clock, .reset, .busy, .rsp_strobe,
   .rsp_gcd_value, .rsp_coeff_a, .rsp_coeff_b
);
